// ===== sv/hpe_pkg.sv =====
// ----------------------------------------------------------------------------
// hpe_pkg
// Types, widths, register indexes and saturation helper for the Horner
// polynomial evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

	// defaults for the top-level parameters
	localparam int MAX_DEGREE_DEF = 6;
	localparam int FRAC_BITS_DEF  = 8;

	// fixed field widths
	localparam int DATA_W    = 16;               // Q8.8 coefficients and x
	localparam int ACC_W     = 32;               // Q16.16 accumulator
	localparam int DEG_W     = 3;
	localparam int NUM_COEFS = 7;
	localparam int COEF_IDX_W = 3;
	localparam int PROD_W    = ACC_W + DATA_W;   // full acc * x product
	localparam int SUM_W     = PROD_W + 1;       // product term + coefficient term
	localparam int CFG_IDX_W = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEGREE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_BASE = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = CFG_IDX_W'(NUM_COEFS);

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [ACC_W-1:0]  acc_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef logic [DEG_W-1:0]         deg_t;

	typedef struct packed {
		acc_t acc;
		logic ovf;
	} sat_t;

	// clamp a step sum to the signed 32-bit range
	function automatic sat_t sat_acc(input sum_t v);
		sat_t r;
		logic all_one;
		logic all_zero;
		all_one  = &v[SUM_W-1:ACC_W-1];
		all_zero = ~|v[SUM_W-1:ACC_W-1];
		if (all_one || all_zero) begin
			r.acc = v[ACC_W-1:0];
			r.ovf = 1'b0;
		end else if (v[SUM_W-1]) begin
			r.acc = {1'b1, {(ACC_W-1){1'b0}}};
			r.ovf = 1'b1;
		end else begin
			r.acc = {1'b0, {(ACC_W-1){1'b1}}};
			r.ovf = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== sv/horner_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// horner_polynomial_evaluator
// Fixed-point P(x) by Horner's rule, one fully unrolled pipeline stage pair
// per step, saturating Q16.16 accumulator with sticky overflow flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake                 | payload
//  --------+---------------------------+-------------------------------------
//  in      | in_valid / in_stall       | x_value (Q8.8)
//  out     | out_valid / out_stall     | poly_value (Q16.16), overflow
//  cfg     | cfg_we, cfg_index         | cfg_data (degree, coef_0..coef_6)
//
// One beat enters per cycle while the pipe is not frozen. A head stage loads
// the top coefficient; each Horner step then takes two stages: a 32x16
// multiply, then the shift, coefficient add and saturate.
// Reset clears valid bits and configuration registers (degree 0, all coefs 0).
// The whole pipe freezes while the output holds a beat and out_stall is high;
// in_stall follows that same hold, so no beat is dropped or repeated.
// Lower degrees run through the same stages: coefficients above the degree
// read as zero, so the accumulator stays exactly zero until the top one.
//
module horner_polynomial_evaluator #(
	parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = hpe_pkg::FRAC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic signed [hpe_pkg::DATA_W-1:0] x_value,
	// output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [hpe_pkg::ACC_W-1:0]  poly_value,
	output logic                            overflow,
	// configuration
	input  logic                            cfg_we,
	input  logic [hpe_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hpe_pkg::DATA_W-1:0]        cfg_data
);
	import hpe_pkg::*;

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	deg_t  degree_q;
	data_t coef_q [0:NUM_COEFS-1];
	logic [CFG_IDX_W-1:0]  coef_off;
	logic [COEF_IDX_W-1:0] coef_idx;

	assign coef_off = cfg_index - REG_COEF_BASE;
	assign coef_idx = coef_off[COEF_IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int i = 0; i < NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
		end else if (cfg_we) begin
			if (cfg_index == REG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end else if (cfg_index >= REG_COEF_BASE && cfg_index <= REG_COEF_LAST) begin
				coef_q[coef_idx] <= cfg_data;
			end
		end
	end

	// effective degree: anything above the pipe depth runs as MAX_DEGREE
	deg_t deg_eff;
	assign deg_eff = (degree_q > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree_q;

	// ------------------------------------------------------------------
	// pipeline control: one global advance
	// ------------------------------------------------------------------
	logic adv;
	// add-stage registers; index 0 is the head stage, MAX_DEGREE the output
	logic  vld_a_s [0:MAX_DEGREE];
	logic  ovf_a_s [0:MAX_DEGREE];
	acc_t  acc_s   [0:MAX_DEGREE];
	data_t x_a_s   [0:MAX_DEGREE];
	// multiply-stage registers
	logic  vld_m_s [0:MAX_DEGREE-1];
	logic  ovf_m_s [0:MAX_DEGREE-1];
	prod_t prod_s  [0:MAX_DEGREE-1];
	data_t x_m_s   [0:MAX_DEGREE-1];

	assign adv      = !(vld_a_s[MAX_DEGREE] && out_stall);
	assign in_stall = !adv;

	// ------------------------------------------------------------------
	// head stage: load the top coefficient (zero if above the degree)
	// ------------------------------------------------------------------
	acc_t head_acc;
	assign head_acc = (deg_eff < DEG_W'(MAX_DEGREE)) ? '0 :
		(ACC_W'(coef_q[MAX_DEGREE]) <<< FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_a_s[0] <= 1'b0;
		end else if (adv) begin
			vld_a_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			acc_s[0]   <= head_acc;
			x_a_s[0]   <= x_value;
			ovf_a_s[0] <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Horner steps, coefficient index MAX_DEGREE-1 down to 0
	// ------------------------------------------------------------------
	for (genvar k = 0; k < MAX_DEGREE; k++) begin : g_step
		localparam int CI = MAX_DEGREE - 1 - k;

		// multiply stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_m_s[k] <= 1'b0;
			end else if (adv) begin
				vld_m_s[k] <= vld_a_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s[k]  <= PROD_W'(acc_s[k]) * PROD_W'(x_a_s[k]);
				x_m_s[k]   <= x_a_s[k];
				ovf_m_s[k] <= ovf_a_s[k];
			end
		end

		// shift, add coefficient, saturate
		prod_t shifted;
		sum_t  coef_term;
		sum_t  step_sum;
		sat_t  step_sat;

		assign shifted   = prod_s[k] >>> FRAC_BITS;
		assign coef_term = (DEG_W'(CI) > deg_eff) ? '0 :
			(SUM_W'(coef_q[CI]) <<< FRAC_BITS);
		assign step_sum  = SUM_W'(shifted) + coef_term;
		assign step_sat  = sat_acc(step_sum);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_a_s[k+1] <= 1'b0;
			end else if (adv) begin
				vld_a_s[k+1] <= vld_m_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				acc_s[k+1]   <= step_sat.acc;
				x_a_s[k+1]   <= x_m_s[k];
				ovf_a_s[k+1] <= ovf_m_s[k] | step_sat.ovf;
			end
		end
	end

	// ------------------------------------------------------------------
	// output: last add stage is the output register
	// ------------------------------------------------------------------
	assign out_valid  = vld_a_s[MAX_DEGREE];
	assign poly_value = acc_s[MAX_DEGREE];
	assign overflow   = ovf_a_s[MAX_DEGREE];

endmodule

// ===== tb/horner_result_checker.sv =====
// ----------------------------------------------------------------------------
// horner_result_checker
// Watches the input, output and configuration ports of the Horner evaluator,
// keeps its own copy of the registers, predicts P(x) for every accepted beat
// and compares each output beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module horner_result_checker #(
	parameter int MAX_DEGREE = hpe_pkg::MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = hpe_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  hpe_pkg::data_t                x_value,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  hpe_pkg::acc_t                 poly_value,
	input  logic                          overflow,
	input  logic                          cfg_we,
	input  logic [hpe_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hpe_pkg::DATA_W-1:0]    cfg_data,
	output int                            fails,
	output int                            pending,
	output int                            checked,
	output int                            saturated
);
	timeunit 1ns;
	timeprecision 1ps;
	import hpe_pkg::*;

	localparam longint ACC_MAX = 64'sd2147483647;
	localparam longint ACC_MIN = -64'sd2147483648;

	typedef struct packed {
		acc_t value;
		logic ovf;
	} point_result_t;

	deg_t          deg_reg;
	data_t         coef_reg [NUM_COEFS];
	point_result_t expected_q [$];

	// Horner chain on 64-bit integers, clamped after every step, sticky flag
	function automatic point_result_t eval_poly(input data_t x);
		point_result_t r;
		longint acc;
		longint scale;
		int top;
		scale = longint'(1) <<< FRAC_BITS;
		top = (int'(deg_reg) > MAX_DEGREE) ? MAX_DEGREE : int'(deg_reg);
		r.ovf = 1'b0;
		acc = longint'(coef_reg[top]) * scale;
		for (int i = top - 1; i >= 0; i--) begin
			acc = ((acc * longint'(x)) >>> FRAC_BITS) + longint'(coef_reg[i]) * scale;
			if (acc > ACC_MAX) begin
				acc = ACC_MAX;
				r.ovf = 1'b1;
			end else if (acc < ACC_MIN) begin
				acc = ACC_MIN;
				r.ovf = 1'b1;
			end
		end
		r.value = acc_t'(acc);
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("%0t: mismatch in %s at result %0d: got %0h, expected %0h",
			$realtime, what, checked, got, want);
		fails++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		point_result_t want;
		if (!arst_n) begin
			deg_reg = '0;
			foreach (coef_reg[i]) coef_reg[i] = '0;
			expected_q.delete();
			fails     = 0;
			pending   = 0;
			checked   = 0;
			saturated = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_DEGREE)
					deg_reg = cfg_data[DEG_W-1:0];
				else if (cfg_index >= REG_COEF_BASE && cfg_index <= REG_COEF_LAST)
					coef_reg[cfg_index - REG_COEF_BASE] = data_t'(cfg_data);
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report_mismatch("beat with nothing pending", poly_value, 0);
				end else begin
					want = expected_q.pop_front();
					if (poly_value !== want.value)
						report_mismatch("poly_value", poly_value, want.value);
					if (overflow !== want.ovf)
						report_mismatch("overflow", overflow, want.ovf);
					checked++;
					if (want.ovf)
						saturated++;
				end
			end
			if (in_valid && !in_stall)
				expected_q.push_back(eval_poly(x_value));
			pending = expected_q.size();
		end
	end

endmodule

// ===== tb/tb_horner_polynomial_evaluator.sv =====
// ----------------------------------------------------------------------------
// tb_horner_polynomial_evaluator
// Drives x beats and register settings into the Horner evaluator with random
// gaps and output stalls; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_horner_polynomial_evaluator;
	timeunit 1ns;
	timeprecision 1ps;
	import hpe_pkg::*;

	// 1 + 2*MAX_DEGREE stages through the unrolled chain
	localparam int PIPE_LAT   = 1 + 2 * MAX_DEGREE_DEF;
	localparam int NUM_PHASES = 12;
	localparam int PHASE_LEN  = 100;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_stall;
	data_t                x_value   = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	acc_t                 poly_value;
	logic                 overflow;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0]    cfg_data  = '0;

	int mism_count;
	int outstanding;
	int results_seen;
	int saturated_seen;

	// idling intensity per side: 0 none, 1 light, 2 heavy
	int send_mode  = 0;
	int stall_mode = 0;
	int stall_left = 0;
	int settings   = 0;

	data_t coef_set [NUM_COEFS];

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	horner_polynomial_evaluator #(
		.MAX_DEGREE(MAX_DEGREE_DEF),
		.FRAC_BITS (FRAC_BITS_DEF)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_value   (x_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.poly_value(poly_value),
		.overflow  (overflow),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	horner_result_checker #(
		.MAX_DEGREE(MAX_DEGREE_DEF),
		.FRAC_BITS (FRAC_BITS_DEF)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_value   (x_value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.poly_value(poly_value),
		.overflow  (overflow),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (mism_count),
		.pending   (outstanding),
		.checked   (results_seen),
		.saturated (saturated_seen)
	);

	// idle length: mostly short, now and then a long one
	function automatic int pick_idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		else if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// receiver side: random stall runs, held as a counted run once started
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (stall_mode != 0 &&
				$urandom_range(0, 99) < ((stall_mode == 1) ? 20 : 45)) begin
			out_stall <= 1'b1;
			stall_left = pick_idle_len() - 1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// one x beat; valid stays up across back-to-back beats
	task automatic send_point(input data_t x);
		int gap;
		gap = 0;
		if (send_mode != 0 && $urandom_range(0, 99) < ((send_mode == 1) ? 25 : 50))
			gap = pick_idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		x_value  <= x;
		do @(posedge clk); while (in_stall);
	endtask

	// drop valid and wait until every predicted beat has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	// degree, then all seven coefficients, then one stray index that must be ignored
	task automatic load_setting(input deg_t deg);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEGREE;
		// upper data bits are don't-care for the degree register
		cfg_data  <= {13'($urandom), deg};
		@(posedge clk);
		for (int i = 0; i < NUM_COEFS; i++) begin
			cfg_index <= REG_COEF_BASE + CFG_IDX_W'(i);
			cfg_data  <= coef_set[i];
			@(posedge clk);
		end
		cfg_index <= CFG_IDX_W'($urandom_range(NUM_COEFS + 1, 15));
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings++;
	endtask

	// coefficient families: full range, small, all max, all min, alternating, sparse
	task automatic roll_setting(input int phase);
		deg_t deg;
		int   fam;
		deg = (phase < 8) ? deg_t'(phase) : deg_t'($urandom_range(0, 7));
		fam = phase % 6;
		for (int i = 0; i < NUM_COEFS; i++) begin
			unique case (fam)
				0: coef_set[i] = data_t'($urandom);
				1: coef_set[i] = data_t'($urandom_range(0, 1535) - 768);
				2: coef_set[i] = 16'sh7fff;
				3: coef_set[i] = 16'sh8000;
				4: coef_set[i] = (i % 2) ? 16'sh7fff : 16'sh8000;
				default: coef_set[i] = (i == int'(deg) || i == 0) ? data_t'($urandom) : '0;
			endcase
		end
		load_setting(deg);
	endtask

	// x mix: half within +-2.0 so results stay in range, some full range, some corners
	function automatic data_t roll_x();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return data_t'($urandom_range(0, 1023) - 512);
		else if (r < 8)
			return data_t'($urandom);
		unique case ($urandom_range(0, 6))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'sh0100;
			3: return -16'sh0100;
			4: return 16'sh0001;
			5: return -16'sh0001;
			default: return '0;
		endcase
	endfunction

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_mode  = 1;
		stall_mode = 1;

		// registers at reset: degree zero, all coefficients zero
		send_point(16'sh7fff);
		send_point(16'sh8000);

		// degree zero returns the constant term whatever x is
		foreach (coef_set[i]) coef_set[i] = data_t'($urandom);
		coef_set[0] = 16'sh8000;
		load_setting(3'd0);
		send_point('0);
		send_point(16'sh7fff);
		send_point(16'sh8000);

		// degree register at 7 acts as the maximum degree; all max saturates
		foreach (coef_set[i]) coef_set[i] = 16'sh7fff;
		load_setting(3'd7);
		send_point(16'sh7fff);
		send_point(16'sh8000);
		send_point(16'sh0100);
		send_point('0);

		// all min at full degree: clamps at both ends as x flips sign
		foreach (coef_set[i]) coef_set[i] = 16'sh8000;
		load_setting(3'd6);
		send_point(16'sh7fff);
		send_point(16'sh8000);
		send_point(-16'sh0001);
		send_point(16'sh0001);

		// 1 + x: exact values, including a negative x
		foreach (coef_set[i]) coef_set[i] = 16'sh0100;
		load_setting(3'd1);
		send_point(16'sh0100);
		send_point(-16'sh0100);
		send_point(16'sh0200);

		// mid degree, random coefficients, single-LSB and bit-pattern x
		foreach (coef_set[i]) coef_set[i] = data_t'($urandom);
		load_setting(3'd3);
		send_point(16'sh0001);
		send_point(-16'sh0001);
		send_point(16'sh5555);
		send_point(-16'sh5556);

		// random phases; idle modes rotate through three pairings, so each side runs with
		// no idling, light and heavy idling, but never both sides without idling at once
		for (int p = 0; p < NUM_PHASES; p++) begin
			send_mode  = p % 3;
			stall_mode = (p + 1) % 3;
			roll_setting(p);
			for (int n = 0; n < PHASE_LEN; n++) begin
				// hold off until the pipe is empty, then resume mid-phase
				if (p % 4 == 1 && n == PHASE_LEN / 2)
					wait_idle();
				send_point(roll_x());
			end
		end

		wait_idle();
		repeat (PIPE_LAT + 4) @(posedge clk);

		$display("Checked %0d points over %0d register settings, degrees 0 to 7",
			results_seen, settings);
		$display("%0d results clamped, %0d mismatches", saturated_seen, mism_count);
		if (mism_count == 0 && outstanding == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// watchdog: several times the slowest legal run
	initial begin : watchdog
		#10_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/hpe_pkg.sv
sv/horner_polynomial_evaluator.sv
tb/horner_result_checker.sv
tb/tb_horner_polynomial_evaluator.sv
